>>> sv/gar_pkg.sv
package gar_pkg;

    localparam int VTX_W = 7;
    localparam int VCNT_W = 7;
    localparam logic [VCNT_W-1:0] VCOUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_COMPL  = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    // operations of the shared row unit
    typedef enum logic [1:0] {
        ROP_SET   = 2'd0,
        ROP_CLR   = 2'd1,
        ROP_FLIP  = 2'd2,
        ROP_MERGE = 2'd3
    } t_rowop;

    typedef struct packed {
        t_kind              kind;
        logic [VTX_W-1:0]   vertex_a;
        logic [VTX_W-1:0]   vertex_b;
    } t_item;

    typedef struct packed {
        logic reachable;
        logic in_range;
    } t_result;

endpackage

>>> sv/graph_adjacency_reachability_top.sv
// Add/remove edge: reads and rewrites each endpoint row in turn, then strobes the result.
// Complement: one adjacency RAM row read and rewritten per vertex.
// Query: scans the vertices one per cycle through the single RAM read port, repeating
//   passes until b is reached or no vertex is pending; no scan if a==b or out of range.
// One item at a time; o_done lasts one cycle and the next item may start in that cycle.
// Synchronous active-low reset empties the graph at once through per-row valid bits.
module graph_adjacency_reachability_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  gar_pkg::t_item               i_item,
    output logic                         o_done,
    output gar_pkg::t_result             o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gar_pkg::VCNT_W-1:0]   i_cfg_data
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = (VW + 1 > gar_pkg::VCNT_W) ? VW + 1 : gar_pkg::VCNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ED_RD = 6'b000010,
        S_ED_WR = 6'b000100,
        S_CP_RD = 6'b001000,
        S_CP_WR = 6'b010000,
        S_QRY   = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    gar_pkg::t_item                r_item, n_item;
    logic                          r_side, n_side;
    logic [CW-1:0]                 r_ptr, n_ptr;
    logic [MAX_VERTICES-1:0]       r_visited, n_visited;
    logic [MAX_VERTICES-1:0]       r_pending, n_pending;
    logic                          r_inflight, n_inflight;
    logic [MAX_VERTICES-1:0]       r_rowv, n_rowv;
    logic                          r_rdv;
    logic                          r_done, n_done;
    gar_pkg::t_result              r_res, n_res;
    logic [gar_pkg::VCNT_W-1:0]    r_vcount;

    logic [CW-1:0]                 eff;
    logic [MAX_VERTICES-1:0]       use_mask;
    logic [MAX_VERTICES-1:0]       a_sel;
    logic [MAX_VERTICES-1:0]       col_sel;
    logic [VW-1:0]                 col_idx;
    logic [VW-1:0]                 a_idx, b_idx, p_idx;
    logic [CW-1:0]                 ptr_inc;
    logic                          in_ok;
    logic                          issue;
    logic [MAX_VERTICES-1:0]       new_bits;

    logic                          ram_we;
    logic [VW-1:0]                 ram_waddr;
    logic [VW-1:0]                 ram_raddr;
    logic [MAX_VERTICES-1:0]       ram_rdata;
    logic [MAX_VERTICES-1:0]       rd_row;
    gar_pkg::t_rowop               rop;
    logic [MAX_VERTICES-1:0]       rop_row;

    assign eff = (CW'(r_vcount) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(r_vcount);
    assign a_idx   = VW'(r_item.vertex_a);
    assign b_idx   = VW'(r_item.vertex_b);
    assign p_idx   = r_ptr[VW-1:0];
    assign ptr_inc = r_ptr + CW'(1);
    assign in_ok   = (CW'(i_item.vertex_a) < eff) && (CW'(i_item.vertex_b) < eff);
    assign rd_row  = r_rdv ? ram_rdata : '0;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            use_mask[i] = (CW'(i) < eff);
            a_sel[i]    = (VW'(i_item.vertex_a) == VW'(i));
            col_sel[i]  = (col_idx == VW'(i));
        end
    end

    // row unit operand selection
    always_comb begin
        rop       = gar_pkg::ROP_MERGE;
        col_idx   = p_idx;
        ram_waddr = p_idx;
        if (r_state == S_ED_WR) begin
            rop       = (r_item.kind == gar_pkg::KIND_ADD) ? gar_pkg::ROP_SET
                                                          : gar_pkg::ROP_CLR;
            col_idx   = r_side ? a_idx : b_idx;
            ram_waddr = r_side ? b_idx : a_idx;
        end else if (r_state == S_CP_WR) begin
            rop = gar_pkg::ROP_FLIP;
        end
    end

    gar_rowop #(
        .W (MAX_VERTICES)
    ) u_rowop (
        .i_op      (rop),
        .i_row     (rd_row),
        .i_sel     (col_sel),
        .i_mask    (use_mask),
        .i_visited (r_visited),
        .o_row     (rop_row)
    );

    gar_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (rop_row),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_side     = r_side;
        n_ptr      = r_ptr;
        n_visited  = r_visited;
        n_pending  = r_pending;
        n_inflight = 1'b0;
        n_rowv     = r_rowv;
        n_done     = 1'b0;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_raddr  = '0;
        issue      = 1'b0;
        new_bits   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    if (i_item.kind == gar_pkg::KIND_COMPL) begin
                        n_res = '{reachable: 1'b0, in_range: 1'b1};
                        if (eff == '0) begin
                            n_done = 1'b1;
                        end else begin
                            n_ptr   = '0;
                            n_state = S_CP_RD;
                        end
                    end else if (!in_ok) begin
                        n_res  = '{reachable: 1'b0, in_range: 1'b0};
                        n_done = 1'b1;
                    end else if (i_item.kind == gar_pkg::KIND_QUERY) begin
                        if (i_item.vertex_a == i_item.vertex_b) begin
                            n_res  = '{reachable: 1'b1, in_range: 1'b1};
                            n_done = 1'b1;
                        end else begin
                            n_res     = '{reachable: 1'b0, in_range: 1'b1};
                            n_visited = a_sel;
                            n_pending = a_sel;
                            n_ptr     = '0;
                            n_state   = S_QRY;
                        end
                    end else begin
                        n_res   = '{reachable: 1'b0, in_range: 1'b1};
                        n_side  = 1'b0;
                        n_state = S_ED_RD;
                    end
                end
            end
            S_ED_RD: begin
                ram_raddr = r_side ? b_idx : a_idx;
                n_state   = S_ED_WR;
            end
            S_ED_WR: begin
                ram_we            = 1'b1;
                n_rowv[ram_waddr] = 1'b1;
                if (r_side) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_side  = 1'b1;
                    n_state = S_ED_RD;
                end
            end
            S_CP_RD: begin
                ram_raddr = p_idx;
                n_state   = S_CP_WR;
            end
            S_CP_WR: begin
                ram_we            = 1'b1;
                n_rowv[ram_waddr] = 1'b1;
                n_ptr             = ptr_inc;
                if (ptr_inc == eff) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            S_QRY: begin
                // merge the row read last cycle, fetch the next pending vertex
                new_bits   = r_inflight ? rop_row : '0;
                issue      = r_pending[p_idx];
                ram_raddr  = p_idx;
                n_inflight = issue;
                n_visited  = r_visited | new_bits;
                n_pending  = (r_pending & ~(issue ? col_sel : '0)) | new_bits;
                n_ptr      = (ptr_inc == eff) ? '0 : ptr_inc;
                if (n_visited[b_idx]) begin
                    n_res   = '{reachable: 1'b1, in_range: 1'b1};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if ((n_pending == '0) && !issue) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_inflight <= 1'b0;
            r_rowv     <= '0;
            r_done     <= 1'b0;
            r_vcount   <= gar_pkg::VCOUNT_RST;
        end else begin
            r_state    <= n_state;
            r_inflight <= n_inflight;
            r_rowv     <= n_rowv;
            r_done     <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_side    <= n_side;
        r_ptr     <= n_ptr;
        r_visited <= n_visited;
        r_pending <= n_pending;
        r_res     <= n_res;
        r_rdv     <= r_rowv[ram_raddr];
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != S_IDLE) || $past(i_start))
        else $error("result strobe without an item in progress");

    a_reach_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_result.reachable || o_result.in_range))
        else $error("reachable reported for an ignored item");

    a_pending_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> ((r_pending & ~r_visited) == '0))
        else $error("pending vertex outside the visited set");

endmodule

>>> sv/gar_ram.sv
module gar_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/gar_rowop.sv
module gar_rowop #(
    parameter int W = 64
) (
    input  gar_pkg::t_rowop i_op,
    input  logic [W-1:0]    i_row,
    input  logic [W-1:0]    i_sel,
    input  logic [W-1:0]    i_mask,
    input  logic [W-1:0]    i_visited,
    output logic [W-1:0]    o_row
);

    always_comb begin
        unique case (i_op)
            gar_pkg::ROP_SET:   o_row = i_row | i_sel;
            gar_pkg::ROP_CLR:   o_row = i_row & ~i_sel;
            // toggle every live column but the diagonal
            gar_pkg::ROP_FLIP:  o_row = i_row ^ (i_mask & ~i_sel);
            // neighbors in use that are not yet visited
            gar_pkg::ROP_MERGE: o_row = i_row & i_mask & ~i_visited;
            default:            o_row = i_row;
        endcase
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        bit                         cfg_row;
        logic [gar_pkg::VCNT_W-1:0] cfg_val;
        gar_pkg::t_item             op;
        bit                         typed;
        gar_pkg::t_result           want;
    } t_step;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    gar_pkg::t_item             item = '0;
    logic                       done;
    gar_pkg::t_result           result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [gar_pkg::VCNT_W-1:0] cfg_data = '0;

    // typed expectation travels with the item it belongs to
    bit                         item_typed = 1'b0;
    gar_pkg::t_result           item_want = '0;

    // graph predictor state
    logic [63:0]                adj_rows [64];
    logic [gar_pkg::VCNT_W-1:0] vcount_model = gar_pkg::VCOUNT_RST;

    gar_pkg::t_result           answer_q [$];
    t_step                      plan [$];
    int                         mismatches = 0;
    int                         quiet_cycles = 0;
    bit                         quiet;
    gar_pkg::t_result           predicted;
    gar_pkg::t_result           oldest;

    graph_adjacency_reachability_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (item),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial begin
        for (int r = 0; r < 64; r++) begin
            adj_rows[r] = '0;
        end
    end

    function automatic int live_count();
        return (vcount_model > 7'd64) ? 64 : int'(vcount_model);
    endfunction

    // grow the visited set one frontier round at a time
    function automatic bit reaches(input int a, input int b, input int n);
        logic [63:0] seen;
        logic [63:0] front;
        logic [63:0] grow;
        logic [63:0] mask;
        mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        seen = 64'd1 << a;
        front = seen;
        for (int r = 0; r < n; r++) begin
            grow = '0;
            for (int v = 0; v < n; v++) begin
                if (front[v]) grow |= adj_rows[v];
            end
            grow &= mask & ~seen;
            seen |= grow;
            front = grow;
            if (grow == '0) break;
        end
        return seen[b];
    endfunction

    function automatic gar_pkg::t_result graph_apply(input gar_pkg::t_item it);
        gar_pkg::t_result res;
        int n;
        int a;
        int b;
        n = live_count();
        a = int'(it.vertex_a);
        b = int'(it.vertex_b);
        res = '0;
        res.in_range = (a < n) && (b < n);
        case (it.kind)
            gar_pkg::KIND_COMPL: begin
                for (int u = 0; u < n; u++) begin
                    for (int v = 0; v < n; v++) begin
                        if (u != v) adj_rows[u][v] = ~adj_rows[u][v];
                    end
                end
                res.in_range = 1'b1;
            end
            gar_pkg::KIND_ADD: begin
                if (res.in_range) begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            gar_pkg::KIND_REMOVE: begin
                if (res.in_range) begin
                    adj_rows[a][b] = 1'b0;
                    adj_rows[b][a] = 1'b0;
                end
            end
            default: begin
                if (res.in_range) res.reachable = (a == b) || reaches(a, b, n);
            end
        endcase
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic want, input logic got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s expected %0b got %0b", $time, field, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            quiet = 1'b1;
            if (done) begin
                quiet = 1'b0;
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result %b with no item pending", $time, result);
                    end
                end else begin
                    oldest = answer_q.pop_front();
                    if (result.reachable !== oldest.reachable) begin
                        note_mismatch("reachable", oldest.reachable, result.reachable);
                    end
                    if (result.in_range !== oldest.in_range) begin
                        note_mismatch("in_range", oldest.in_range, result.in_range);
                    end
                end
            end
            if (start && !busy) begin
                quiet = 1'b0;
                predicted = graph_apply(item);
                answer_q = {answer_q, (item_typed ? item_want : predicted)};
            end
            if (cfg_valid && cfg_ready) begin
                quiet = 1'b0;
                vcount_model = cfg_data;
            end
            quiet_cycles = quiet ? quiet_cycles + 1 : 0;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_step mk_op(input gar_pkg::t_kind k, input int a, input int b,
                                    input bit typed, input logic [1:0] w);
        t_step s;
        s.cfg_row = 1'b0;
        s.cfg_val = '0;
        s.op.kind = k;
        s.op.vertex_a = gar_pkg::VTX_W'(a);
        s.op.vertex_b = gar_pkg::VTX_W'(b);
        s.typed = typed;
        s.want = gar_pkg::t_result'(w);
        return s;
    endfunction

    function automatic t_step mk_cfg(input int v);
        t_step s;
        s = mk_op(gar_pkg::KIND_ADD, 0, 0, 1'b0, 2'b00);
        s.cfg_row = 1'b1;
        s.cfg_val = gar_pkg::VCNT_W'(v);
        return s;
    endfunction

    function automatic void add_row(input t_step s);
        plan = {plan, s};
    endfunction

    function automatic gar_pkg::t_item rand_item(input int n);
        gar_pkg::t_item it;
        int r;
        r = $urandom_range(99);
        if (r < 45) it.kind = gar_pkg::KIND_ADD;
        else if (r < 65) it.kind = gar_pkg::KIND_REMOVE;
        else if (r < 70) it.kind = gar_pkg::KIND_COMPL;
        else it.kind = gar_pkg::KIND_QUERY;
        // mostly in-range vertices; the rest spans the whole field
        if (n > 0 && $urandom_range(99) >= 8) begin
            it.vertex_a = gar_pkg::VTX_W'($urandom_range(n - 1));
        end else begin
            it.vertex_a = gar_pkg::VTX_W'($urandom);
        end
        if (n > 0 && $urandom_range(99) >= 8) begin
            it.vertex_b = gar_pkg::VTX_W'($urandom_range(n - 1));
        end else begin
            it.vertex_b = gar_pkg::VTX_W'($urandom);
        end
        return it;
    endfunction

    task automatic issue_item(input gar_pkg::t_item it, input bit typed,
                              input gar_pkg::t_result want, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        item_typed <= typed;
        item_want <= want;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_vcount(input logic [gar_pkg::VCNT_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0 || busy) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph_count [9];
        int ph_items [9];
        int ph_idle [9];
        int n;

        ph_count = '{8, 16, 4, 64, 1, 127, 0, 32, 5};
        ph_items = '{120, 120, 100, 100, 40, 80, 30, 100, 60};
        ph_idle  = '{0, 73, 34, 0, 73, 34, 0, 73, 34};

        add_row(mk_op(gar_pkg::KIND_QUERY, 0, 0, 1'b1, 2'b11));
        add_row(mk_op(gar_pkg::KIND_QUERY, 0, 1, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 127, 127, 1'b1, 2'b00));
        add_row(mk_op(gar_pkg::KIND_ADD, 0, 63, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 63, 0, 1'b0, 2'b00));
        add_row(mk_op(gar_pkg::KIND_ADD, 64, 1, 1'b1, 2'b00));
        add_row(mk_op(gar_pkg::KIND_ADD, 5, 5, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_REMOVE, 0, 63, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_COMPL, 127, 127, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 0, 63, 1'b0, 2'b00));
        add_row(mk_op(gar_pkg::KIND_REMOVE, 1, 2, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 1, 2, 1'b0, 2'b00));
        add_row(mk_op(gar_pkg::KIND_COMPL, 0, 0, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 2, 1, 1'b0, 2'b00));
        add_row(mk_op(gar_pkg::KIND_QUERY, 5, 6, 1'b0, 2'b00));
        add_row(mk_op(gar_pkg::KIND_ADD, 2, 40, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_REMOVE, 127, 0, 1'b1, 2'b00));
        // shrink: the edge to vertex 40 goes stale
        add_row(mk_cfg(3));
        add_row(mk_op(gar_pkg::KIND_QUERY, 0, 40, 1'b1, 2'b00));
        add_row(mk_op(gar_pkg::KIND_QUERY, 2, 0, 1'b0, 2'b00));
        add_row(mk_op(gar_pkg::KIND_ADD, 0, 3, 1'b1, 2'b00));
        add_row(mk_cfg(0));
        add_row(mk_op(gar_pkg::KIND_COMPL, 0, 0, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 0, 0, 1'b1, 2'b00));
        // oversized count saturates at 64
        add_row(mk_cfg(127));
        add_row(mk_op(gar_pkg::KIND_QUERY, 63, 63, 1'b1, 2'b11));
        add_row(mk_op(gar_pkg::KIND_QUERY, 64, 64, 1'b1, 2'b00));
        add_row(mk_cfg(1));
        add_row(mk_op(gar_pkg::KIND_COMPL, 0, 0, 1'b1, 2'b01));
        add_row(mk_op(gar_pkg::KIND_QUERY, 0, 0, 1'b1, 2'b11));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg_row) write_vcount(plan[i].cfg_val);
            else issue_item(plan[i].op, plan[i].typed, plan[i].want, 0);
        end

        for (int p = 0; p < 9; p++) begin
            write_vcount(gar_pkg::VCNT_W'(ph_count[p]));
            n = (ph_count[p] > 64) ? 64 : ph_count[p];
            for (int k = 0; k < ph_items[p]; k++) begin
                issue_item(rand_item(n), 1'b0, '0, ph_idle[p]);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
